>>> rtl/line_follower_wheel_gain_steer_core_defines.svh
// Assertion helpers shared by the steering core.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef LINE_FOLLOWER_WHEEL_GAIN_STEER_CORE_DEFINES_SVH
`define LINE_FOLLOWER_WHEEL_GAIN_STEER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LFWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LFWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lfws_pkg.sv
package lfws_pkg;

    // Default gain format: Q.12, so 1.0 is 4096
    localparam int GAIN_FRAC_BITS_DEF = 12;

    // Field and register widths
    localparam int SPEED_W   = 8;
    localparam int STEP_W    = 13;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd150;
    localparam logic [STEP_W-1:0]  STEER_STEP_RST = 13'd205;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED  = 4'd0,
        REG_STEER_STEP = 4'd1
    } cfg_reg_t;

endpackage

>>> rtl/lfws_if.sv
// Sensor sample channel
interface lfws_sample_if;
    logic valid;
    logic ready;
    logic left_outer_white;
    logic left_inner_white;
    logic centre_white;
    logic right_inner_white;
    logic right_outer_white;

    modport source (
        output valid, left_outer_white, left_inner_white, centre_white,
               right_inner_white, right_outer_white,
        input  ready
    );
    modport sink (
        input  valid, left_outer_white, left_inner_white, centre_white,
               right_inner_white, right_outer_white,
        output ready
    );
endinterface

// Wheel duty channel
interface lfws_duty_if
    import lfws_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;

    modport source (
        output valid, right_duty, left_duty,
        input  ready
    );
    modport sink (
        input  valid, right_duty, left_duty,
        output ready
    );
endinterface

>>> rtl/line_follower_wheel_gain_steer_core.sv
// Line follower steering core.
//
// sample (sink): one request carries the five line sensor bits (1 = white).
// duty (source): one request per sample with the right and left wheel PWM
//   duties, each (max_speed * gain) >> GAIN_FRAC_BITS, truncated to 8 bits.
// cfg_we / cfg_index / cfg_data: register write port; index 0 is max_speed,
//   index 1 is steer_step, other indexes are ignored. Write only while idle.
//
// The sample is held in the sample register, then the five sensor steps and
// both multiplies run combinationally into the gain and duty registers, and
// the duty request is raised from the duty register. Throughput is one
// sample per cycle while the duty receiver does not stall; the gain update
// loop closes through the gain registers and the combinational steps alone.
//
// Reset sets both gains to 1.0, max_speed to 150, steer_step to 205 and
// empties both stages. When the duty receiver stalls, a finished result
// holds in the duty register and one more sample is taken into the sample
// register; sample ready then drops until the duty request is taken.
`include "line_follower_wheel_gain_steer_core_defines.svh"

module line_follower_wheel_gain_steer_core
    import lfws_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lfws_sample_if.sink           sample,
    lfws_duty_if.source           duty,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int GW    = GAIN_FRAC_BITS + 1;
    localparam int S2_W  = STEP_W + 1;
    localparam int SUM_W = ((GW > S2_W) ? GW : S2_W) + 1;
    localparam int PROD_W = SPEED_W + GW;

    localparam logic [GW-1:0]    GAIN_ONE   = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [SUM_W-1:0] GAIN_ONE_S = SUM_W'(GAIN_ONE);

    typedef struct packed {
        logic [GW-1:0] outer;
        logic [GW-1:0] inner;
    } gain_pair_t;

    // Raise the outer gain toward 1.0, then lower the inner gain toward 0
    function automatic gain_pair_t steer(gain_pair_t g, logic [S2_W-1:0] step);
        gain_pair_t       r;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] diff;
        r    = g;
        sum  = SUM_W'(g.outer) + SUM_W'(step);
        diff = SUM_W'(g.inner) - SUM_W'(step);
        if (sum < GAIN_ONE_S) begin
            r.outer = sum[GW-1:0];
        end else if (g.outer != GAIN_ONE) begin
            r.outer = GAIN_ONE;
        end else if (SUM_W'(g.inner) > SUM_W'(step)) begin
            r.inner = diff[GW-1:0];
        end else begin
            r.inner = '0;
        end
        return r;
    endfunction

    // Configuration registers
    logic [SPEED_W-1:0] max_speed_reg;
    logic [STEP_W-1:0]  steer_step_reg;

    // Sample stage
    logic smp_valid_reg;
    logic lo_reg, li_reg, ce_reg, ri_reg, ro_reg;

    // Gain state and result stage
    logic [GW-1:0]     right_gain_reg, left_gain_reg;
    logic [GW-1:0]     right_gain_next, left_gain_next;
    logic              out_valid_reg;
    logic [DUTY_W-1:0] right_duty_reg, left_duty_reg;
    logic [DUTY_W-1:0] right_duty_next, left_duty_next;

    logic advance;
    logic do_item;

    assign advance      = !out_valid_reg || duty.ready;
    assign do_item      = advance && smp_valid_reg;
    assign sample.ready = !smp_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_speed_reg  <= MAX_SPEED_RST;
            steer_step_reg <= STEER_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_SPEED:  max_speed_reg  <= cfg_data[SPEED_W-1:0];
                REG_STEER_STEP: steer_step_reg <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture the sensor request
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            smp_valid_reg <= 1'b0;
        end else if (sample.ready) begin
            smp_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (sample.ready && sample.valid) begin
            lo_reg <= sample.left_outer_white;
            li_reg <= sample.left_inner_white;
            ce_reg <= sample.centre_white;
            ri_reg <= sample.right_inner_white;
            ro_reg <= sample.right_outer_white;
        end
    end

    // Apply the five sensors in order, then scale the new gains
    always_comb begin
        gain_pair_t       g;
        logic [S2_W-1:0]  step1;
        logic [S2_W-1:0]  step2;
        logic [PROD_W-1:0] prod_r;
        logic [PROD_W-1:0] prod_l;
        step1 = S2_W'(steer_step_reg);
        step2 = {steer_step_reg, 1'b0};

        // left turns: outer is the right wheel
        g.outer = right_gain_reg;
        g.inner = left_gain_reg;
        if (lo_reg) g = steer(g, step2);
        if (li_reg) g = steer(g, step1);
        if (ce_reg) begin
            g.outer = GAIN_ONE;
            g.inner = GAIN_ONE;
        end

        // right turns: outer is the left wheel
        g = '{outer: g.inner, inner: g.outer};
        if (ri_reg) g = steer(g, step1);
        if (ro_reg) g = steer(g, step2);

        left_gain_next  = g.outer;
        right_gain_next = g.inner;

        prod_r = PROD_W'(max_speed_reg) * PROD_W'(right_gain_next);
        prod_l = PROD_W'(max_speed_reg) * PROD_W'(left_gain_next);
        right_duty_next = prod_r[GAIN_FRAC_BITS +: DUTY_W];
        left_duty_next  = prod_l[GAIN_FRAC_BITS +: DUTY_W];
    end

    // Advance gains and the result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            right_gain_reg <= GAIN_ONE;
            left_gain_reg  <= GAIN_ONE;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= smp_valid_reg;
            if (smp_valid_reg) begin
                right_gain_reg <= right_gain_next;
                left_gain_reg  <= left_gain_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_item) begin
            right_duty_reg <= right_duty_next;
            left_duty_reg  <= left_duty_next;
        end
    end

    assign duty.valid      = out_valid_reg;
    assign duty.right_duty = right_duty_reg;
    assign duty.left_duty  = left_duty_reg;

    // Gains stay within 0 .. 1.0
    `LFWS_ASSERT_NOW(a_gain_range, 1'b1, (right_gain_reg <= GAIN_ONE) && (left_gain_reg <= GAIN_ONE), "gain above 1.0")
    // Steering lowers a wheel only while the other sits at 1.0
    `LFWS_ASSERT_NOW(a_one_gain_full, 1'b1, (right_gain_reg == GAIN_ONE) || (left_gain_reg == GAIN_ONE), "both gains below 1.0")
    // Gains move only when a sample is processed
    `LFWS_ASSERT_NEXT(a_gain_hold, !do_item, $stable(right_gain_reg) && $stable(left_gain_reg), "gain changed without a sample")
    // No result appears from an empty sample stage
    `LFWS_ASSERT_NEXT(a_no_phantom, advance && !smp_valid_reg, !duty.valid, "duty valid without a sample")

endmodule
